/* src/tss_pkg.sv */
// Shared widths and types for the triangle stiffness stencil block.
`default_nettype none
package tss_pkg;
   localparam int COORD_W = 16;
   localparam int DIF_W   = 17;
   localparam int PROD_W  = 34;
   localparam int NUM_W   = 38;
   localparam int NM_W    = 37;
   localparam int DM_W    = 34;
   localparam int HALF_W  = 17;
   localparam int PP_W    = 34;
   localparam int DSQ_W   = 68;
   localparam int REM_W   = 69;
   localparam int QB      = 47;
   localparam int MAG_W   = QB + 1;
   localparam int LANES   = 4;
   localparam int ENT_W   = 32;
   localparam int LVL_W   = 4;
   localparam int CNT_W   = 5;
   localparam int TAG_W   = 16;
   localparam int CAP     = 16;
   localparam int REQ_W   = 120;
   localparam int RSP_W   = 248;
   localparam int USER_W  = 2;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [TAG_W-1:0] tag;
   } side_type;
endpackage
`default_nettype wire

/* src/triangle_stiffness_stencil.sv */
// Top level of the triangle stiffness stencil block: setup pipeline, divider, level emitter.
//
// A triangle request enters on the req_ channel (three Q8.8 vertices, a level count and
// a tag). For each level l below the limited count, one stencil request leaves on the
// rsp_ channel, entries scaled by two to the l and saturated to 32 bits; tlast marks the
// final level of a triangle, tuser carries the degenerate and saturated flags.
// A triangle with a level count of zero produces nothing.
// From an accepted request to its first result there are six setup stages (edge
// differences, products, sums, numerators, split determinant square, divisor), then a
// restoring divider (an entry stage, then one quotient bit per stage), a holding register
// and the output register. The divider takes a new triangle in every cycle unless the
// pipeline is frozen; the level emitter gives one result per level, one per cycle while
// the output register can load, and takes the next triangle as the last level leaves.
// When rsp_tready is low, the output register holds its request, the emitter stops and
// the whole pipeline freezes once its last stage is full; req_tready then drops.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module triangle_stiffness_stencil #(
   parameter int MAX_LEVELS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // x0, y0, x1, y1, x2, y2, level_count, element_tag, zero fill
   input  wire  [tss_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // top_mid, top_right, mid_left, center, mid_right, bottom_left, bottom_mid,
   // level, tag_out, zero fill
   output logic [tss_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast,
   // degenerate, saturated
   output logic [tss_pkg::USER_W-1:0]   rsp_tuser
);
   localparam int DW    = tss_pkg::NM_W + 16 + FRAC_BITS;
   localparam int HI_W  = DW - tss_pkg::QB;
   localparam int CMP_W = (HI_W > tss_pkg::DSQ_W) ? HI_W : tss_pkg::DSQ_W;
   localparam int LIM   = (MAX_LEVELS < tss_pkg::CAP) ? MAX_LEVELS : tss_pkg::CAP;
   localparam int SH_W  = tss_pkg::MAG_W + 15;
   localparam int QB    = tss_pkg::QB;
   localparam int LN    = tss_pkg::LANES;

   logic adv;

   // Stage 1: edge differences.
   logic signed [tss_pkg::DIF_W-1:0] b00_ff, b01_ff, b10_ff, b11_ff;
   logic [6:1]                       pv_ff;
   tss_pkg::side_type                side_ff [1:6];
   tss_pkg::side_type                side_in;
   logic signed [tss_pkg::COORD_W-1:0] x0, y0, x1, y1, x2, y2;
   logic [tss_pkg::CNT_W-1:0]        lc;

   always_comb begin
      x0 = req_tdata[15:0];
      y0 = req_tdata[31:16];
      x1 = req_tdata[47:32];
      y1 = req_tdata[63:48];
      x2 = req_tdata[79:64];
      y2 = req_tdata[95:80];
      lc = req_tdata[100:96];
      side_in.tag = req_tdata[116:101];
      side_in.cnt = ({1'b0, lc} > 6'(LIM)) ? tss_pkg::CNT_W'(LIM) : lc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[5:1], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b00_ff <= tss_pkg::DIF_W'(x1) - tss_pkg::DIF_W'(x0);
         b01_ff <= tss_pkg::DIF_W'(x2) - tss_pkg::DIF_W'(x1);
         b10_ff <= tss_pkg::DIF_W'(y1) - tss_pkg::DIF_W'(y0);
         b11_ff <= tss_pkg::DIF_W'(y2) - tss_pkg::DIF_W'(y1);
         side_ff[1] <= side_in;
         for (int k = 2; k <= 6; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage 2: products.
   logic signed [tss_pkg::PROD_W-1:0] p_ff [0:7];
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= b00_ff * b11_ff;
         p_ff[1] <= b01_ff * b10_ff;
         p_ff[2] <= b11_ff * b11_ff;
         p_ff[3] <= b01_ff * b01_ff;
         p_ff[4] <= b10_ff * b11_ff;
         p_ff[5] <= b00_ff * b01_ff;
         p_ff[6] <= b00_ff * b00_ff;
         p_ff[7] <= b10_ff * b10_ff;
      end
   end

   // Stage 3: determinant and quadratic forms.
   logic signed [tss_pkg::NUM_W-1:0] det_ff, na_ff, nb_ff, nc_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= tss_pkg::NUM_W'(p_ff[0]) - tss_pkg::NUM_W'(p_ff[1]);
         na_ff  <= tss_pkg::NUM_W'(p_ff[2]) + tss_pkg::NUM_W'(p_ff[3]);
         nb_ff  <= -((tss_pkg::NUM_W'(p_ff[4]) + tss_pkg::NUM_W'(p_ff[5])) <<< 1);
         nc_ff  <= tss_pkg::NUM_W'(p_ff[6]) + tss_pkg::NUM_W'(p_ff[7]);
      end
   end

   // Stage 4: numerators and determinant magnitude.
   logic signed [tss_pkg::NUM_W-1:0] num_ff [0:LN-1];
   logic [tss_pkg::DM_W-1:0]         dm_ff;
   logic                             deg4_ff, deg5_ff, deg6_ff;
   logic signed [tss_pkg::NUM_W-1:0] dabs;
   always_comb begin
      dabs = (det_ff < 0) ? -det_ff : det_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff[0] <= nb_ff - nc_ff;
         num_ff[1] <= -nb_ff;
         num_ff[2] <= nb_ff - na_ff;
         num_ff[3] <= (na_ff - nb_ff + nc_ff) <<< 1;
         dm_ff     <= dabs[tss_pkg::DM_W-1:0];
         deg4_ff   <= (det_ff == '0);
      end
   end

   // Stage 5: numerator magnitudes and split square partial products.
   logic [tss_pkg::NM_W-1:0] nm_ff [0:LN-1];
   logic [LN-1:0]            neg5_ff, neg6_ff;
   logic [tss_pkg::PP_W-1:0] hh_ff, hl_ff, ll_ff;
   logic [tss_pkg::HALF_W-1:0] dh, dl;
   always_comb begin
      dh = dm_ff[tss_pkg::DM_W-1:tss_pkg::HALF_W];
      dl = dm_ff[tss_pkg::HALF_W-1:0];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LN; k++) begin
            neg5_ff[k] <= num_ff[k] < 0;
            nm_ff[k]   <= (num_ff[k] < 0) ? tss_pkg::NM_W'(-num_ff[k])
                                          : tss_pkg::NM_W'(num_ff[k]);
         end
         hh_ff   <= dh * dh;
         hl_ff   <= dh * dl;
         ll_ff   <= dl * dl;
         deg5_ff <= deg4_ff;
      end
   end

   // Stage 6: divisor and scaled dividends.
   logic [tss_pkg::DSQ_W-1:0] dsq6_ff;
   logic [DW-1:0]             dvd_ff [0:LN-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         dsq6_ff <= (tss_pkg::DSQ_W'(hh_ff) << (2 * tss_pkg::HALF_W))
                  + (tss_pkg::DSQ_W'(hl_ff) << (tss_pkg::HALF_W + 1))
                  + tss_pkg::DSQ_W'(ll_ff);
         for (int k = 0; k < LN; k++) begin
            dvd_ff[k] <= DW'(nm_ff[k]) << (16 + FRAC_BITS);
         end
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;
      end
   end

   // Divider: entry stage checks the clamp, then one quotient bit per stage.
   logic [tss_pkg::REM_W-1:0] rem_ff [0:QB][0:LN-1];
   logic [QB-1:0]             low_ff [0:QB][0:LN-1];
   logic [QB-1:0]             q_ff   [0:QB][0:LN-1];
   logic [LN-1:0]             ovf_ff [0:QB];
   logic [LN-1:0]             dneg_ff [0:QB];
   logic [tss_pkg::DSQ_W-1:0] dsq_ff [0:QB];
   logic [QB:0]               dv_ff;
   logic [QB:0]               ddeg_ff;
   tss_pkg::side_type         dside_ff [0:QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[QB-1:0], pv_ff[6]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LN; k++) begin
            ovf_ff[0][k] <= CMP_W'(dvd_ff[k][DW-1:QB]) >= CMP_W'(dsq6_ff);
            rem_ff[0][k] <= tss_pkg::REM_W'(dvd_ff[k][DW-1:QB]);
            low_ff[0][k] <= dvd_ff[k][QB-1:0];
            q_ff[0][k]   <= '0;
         end
         dsq_ff[0]   <= dsq6_ff;
         dneg_ff[0]  <= neg6_ff;
         ddeg_ff[0]  <= deg6_ff;
         dside_ff[0] <= side_ff[6];
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      for (genvar k = 0; k < LN; k++) begin : g_lane
         logic [tss_pkg::REM_W:0] trial;
         logic                    fits;
         always_comb begin
            trial = {rem_ff[j-1][k], low_ff[j-1][k][QB-1]};
            fits  = trial >= {1'b0, dsq_ff[j-1]};
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j][k] <= fits ? tss_pkg::REM_W'(trial - {1'b0, dsq_ff[j-1]})
                                    : tss_pkg::REM_W'(trial);
               low_ff[j][k] <= low_ff[j-1][k] << 1;
               q_ff[j][k]   <= {q_ff[j-1][k][QB-2:0], fits};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ovf_ff[j]   <= ovf_ff[j-1];
            dsq_ff[j]   <= dsq_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            ddeg_ff[j]  <= ddeg_ff[j-1];
            dside_ff[j] <= dside_ff[j-1];
         end
      end
   end

   // Level emitter.
   logic [tss_pkg::MAG_W-1:0] mag_in [0:LN-1];
   logic [LN-1:0]             neg_in;
   logic                      hv_ff, hdeg_ff;
   logic [tss_pkg::MAG_W-1:0] hmag_ff [0:LN-1];
   logic [LN-1:0]             hneg_ff;
   logic [tss_pkg::CNT_W-1:0] hcnt_ff;
   logic [tss_pkg::LVL_W-1:0] hlvl_ff;
   logic [tss_pkg::TAG_W-1:0] htag_ff;
   logic                      out_load, hdone, take;

   always_comb begin
      for (int k = 0; k < LN; k++) begin
         if (ddeg_ff[QB]) begin
            mag_in[k] = '0;
         end else if (ovf_ff[QB][k]) begin
            mag_in[k] = tss_pkg::MAG_W'(1) << QB;
         end else begin
            mag_in[k] = {1'b0, q_ff[QB][k]};
         end
         neg_in[k] = dneg_ff[QB][k] && (mag_in[k] != '0);
      end
   end

   logic ov_ff;
   always_comb begin
      out_load = hv_ff && (!ov_ff || rsp_tready);
      hdone    = out_load && ((tss_pkg::CNT_W'(hlvl_ff) + 1'b1) == hcnt_ff);
      take     = dv_ff[QB] && (!hv_ff || hdone);
      adv      = !dv_ff[QB] || take;
      req_tready = adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
      end else if (take) begin
         hv_ff <= dside_ff[QB].cnt != '0;
      end else if (hdone) begin
         hv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hmag_ff <= mag_in;
         hneg_ff <= neg_in;
         hcnt_ff <= dside_ff[QB].cnt;
         htag_ff <= dside_ff[QB].tag;
         hdeg_ff <= ddeg_ff[QB];
         hlvl_ff <= '0;
      end else if (out_load) begin
         hlvl_ff <= hlvl_ff + 1'b1;
      end
   end

   // Scale, saturate and pack one level.
   logic [SH_W-1:0]          sh   [0:LN-1];
   logic [tss_pkg::ENT_W-1:0] ent [0:LN-1];
   logic [LN-1:0]            sat;
   logic [tss_pkg::RSP_W-1:0] data_in;
   always_comb begin
      for (int k = 0; k < LN; k++) begin
         sh[k] = SH_W'(hmag_ff[k]) << hlvl_ff;
         if (hneg_ff[k]) begin
            sat[k] = sh[k] > (SH_W'(1) << 31);
            ent[k] = sat[k] ? 32'h8000_0000 : -sh[k][tss_pkg::ENT_W-1:0];
         end else begin
            sat[k] = sh[k] > SH_W'(32'h7FFF_FFFF);
            ent[k] = sat[k] ? 32'h7FFF_FFFF : sh[k][tss_pkg::ENT_W-1:0];
         end
      end
      data_in = {4'b0, htag_ff, hlvl_ff, ent[0], ent[1], ent[2], ent[3], ent[2],
                 ent[1], ent[0]};
   end

   logic [tss_pkg::RSP_W-1:0]  od_ff;
   logic                       ol_ff;
   logic [tss_pkg::USER_W-1:0] ou_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (out_load) begin
         ov_ff <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (out_load) begin
         od_ff <= data_in;
         ol_ff <= (tss_pkg::CNT_W'(hlvl_ff) + 1'b1) == hcnt_ff;
         ou_ff <= {|sat, hdeg_ff};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;
   assign rsp_tuser  = ou_ff;

   a_hold_nonempty: assert property (@(posedge clock) disable iff (reset)
      hv_ff |-> hcnt_ff != '0)
      else $error("holding register valid with zero level count");
   a_take_free: assert property (@(posedge clock) disable iff (reset)
      take |-> (!hv_ff || hdone))
      else $error("new triangle loaded over an unfinished one");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[223:0] == '0 && !rsp_tuser[1])
      else $error("degenerate result with nonzero entries");
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      out_load && !hdone |=> hlvl_ff == $past(hlvl_ff) + 1'b1)
      else $error("level counter skipped");
endmodule
`default_nettype wire
